FILE: src/i2cm_pkg.sv
package i2cm_pkg;

  // Command codes carried in the op field
  typedef enum logic [2:0] {
    OP_TICK  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_WRITE = 3'd3,
    OP_READ  = 3'd4,
    OP_ACK   = 3'd5,
    OP_WACK  = 3'd6
  } op_t;

  localparam logic [7:0] MSB_MASK = 8'h80;

  // Command word: one item on the command channel
  typedef struct packed {
    logic [2:0] op;
    logic [7:0] tx_byte;
    logic       ack_level;
    logic       sda_in;
  } cmd_t;

  // Result word: one item on the result channel
  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_seen;
    logic       rejected;
  } res_t;

  // Engine state carried between words
  typedef struct packed {
    op_t        active_command;
    logic [4:0] step_count;
    logic [7:0] shift_reg;
    logic       scl_reg;
    logic       sda_reg;
    logic       ack_reg;
    logic [7:0] rx_hold;
  } state_t;

  // Number of pin updates per command
  function automatic logic [4:0] seq_len(input op_t cmd);
    logic [4:0] len;
    unique case (cmd)
      OP_START: len = 5'd4;
      OP_STOP:  len = 5'd3;
      OP_WRITE: len = 5'd24;
      OP_READ:  len = 5'd17;
      OP_ACK:   len = 5'd3;
      OP_WACK:  len = 5'd3;
      default:  len = 5'd0;
    endcase
    return len;
  endfunction

  // Quotient by three for values below 32: (x * 11) >> 5 is exact there
  function automatic logic [3:0] div3(input logic [4:0] x);
    logic [9:0] prod;
    prod = 10'(x) * 10'd11;
    return prod[8:5];
  endfunction

endpackage

FILE: src/i2cm_step.sv
module i2cm_step (
  input  i2cm_pkg::state_t st,
  input  i2cm_pkg::cmd_t   item,
  output i2cm_pkg::state_t st_next,
  output i2cm_pkg::res_t   res
);
  import i2cm_pkg::*;

  logic [3:0] wr_quot;
  logic [1:0] wr_phase;
  logic [2:0] wr_bit;
  logic [4:0] rd_off;
  logic [2:0] rd_bit;
  logic [4:0] step_plus;
  logic       done;
  logic       rej;

  // Bit and phase of the byte sequences
  always_comb begin
    wr_quot  = div3(st.step_count);
    wr_bit   = wr_quot[2:0];
    wr_phase = 2'(st.step_count - 5'(wr_quot) * 5'd3);
    rd_off   = st.step_count - 5'd1;
    rd_bit   = rd_off[3:1];
    step_plus = st.step_count + 5'd1;
  end

  // One pin update, or command load, per word
  always_comb begin
    st_next = st;
    done    = 1'b0;
    rej     = 1'b0;
    if (item.op == OP_TICK) begin
      if (st.active_command != OP_TICK) begin
        unique case (st.active_command)
          OP_START: begin
            unique case (st.step_count)
              5'd0:    st_next.sda_reg = 1'b1;
              5'd1:    st_next.scl_reg = 1'b1;
              5'd2:    st_next.sda_reg = 1'b0;
              default: st_next.scl_reg = 1'b0;
            endcase
          end
          OP_STOP: begin
            unique case (st.step_count)
              5'd0:    st_next.sda_reg = 1'b0;
              5'd1:    st_next.scl_reg = 1'b1;
              default: st_next.sda_reg = 1'b1;
            endcase
          end
          OP_WRITE: begin
            unique case (wr_phase)
              2'd0:    st_next.sda_reg = st.shift_reg[3'd7 - wr_bit];
              2'd1:    st_next.scl_reg = 1'b1;
              default: st_next.scl_reg = 1'b0;
            endcase
          end
          OP_READ: begin
            if (st.step_count == 5'd0) begin
              st_next.sda_reg = 1'b1;
            end else if (!rd_off[0]) begin
              st_next.scl_reg = 1'b1;
              if (item.sda_in) begin
                st_next.shift_reg = st.shift_reg | (MSB_MASK >> rd_bit);
              end
            end else begin
              st_next.scl_reg = 1'b0;
            end
          end
          OP_ACK: begin
            unique case (st.step_count)
              5'd0:    st_next.sda_reg = st.shift_reg[0];
              5'd1:    st_next.scl_reg = 1'b1;
              default: st_next.scl_reg = 1'b0;
            endcase
          end
          OP_WACK: begin
            unique case (st.step_count)
              5'd0:    st_next.sda_reg = 1'b1;
              5'd1: begin
                st_next.scl_reg = 1'b1;
                st_next.ack_reg = item.sda_in;
              end
              default: st_next.scl_reg = 1'b0;
            endcase
          end
          default: ;
        endcase
        st_next.step_count = step_plus;
        // last update of the sequence ends the command
        if (step_plus >= seq_len(st.active_command)) begin
          if (st.active_command == OP_READ) begin
            st_next.rx_hold = st_next.shift_reg;
          end
          st_next.active_command = OP_TICK;
          st_next.step_count     = 5'd0;
          done                   = 1'b1;
        end
      end
    end else if (item.op <= OP_WACK) begin
      if (st.active_command != OP_TICK) begin
        rej = 1'b1;
      end else begin
        st_next.active_command = op_t'(item.op);
        st_next.step_count     = 5'd0;
        if (item.op == OP_WRITE) begin
          st_next.shift_reg = item.tx_byte;
        end else if (item.op == OP_READ) begin
          st_next.shift_reg = 8'd0;
        end else if (item.op == OP_ACK) begin
          st_next.shift_reg = {7'd0, item.ack_level};
        end
      end
    end
  end

  // Result word reflects state after this word
  always_comb begin
    res.scl_level = st_next.scl_reg;
    res.sda_level = st_next.sda_reg;
    res.busy_res  = (st_next.active_command != OP_TICK);
    res.done_res  = done;
    res.rx_byte   = st_next.rx_hold;
    res.ack_seen  = st_next.ack_reg;
    res.rejected  = rej;
  end

endmodule

FILE: src/i2c_master_bit_engine.sv
// I2C master bit engine. Each command word either loads a command (start,
// stop, write byte, read byte, send ack, wait ack) while idle, or, as a tick,
// applies the next SCL/SDA pin update of the loaded command; a command sent
// while one is in progress is flagged rejected and ignored. Exactly one
// result word comes back per command word. The engine takes one word every
// clock cycle while the command channel is not stalled; a word is held in the
// input register when accepted, and one pass through the step logic loads its
// result into the result register, from which it is presented on the result
// channel. Stalling the result channel holds the result; once a word also
// waits in the input register the command channel is stalled in that same
// cycle.
module i2c_master_bit_engine (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  output logic            cmd_stall,
  input  i2cm_pkg::cmd_t  cmd_word,
  output logic            res_valid,
  input  logic            res_stall,
  output i2cm_pkg::res_t  res_word
);
  import i2cm_pkg::*;

  logic   in_valid;
  cmd_t   in_word;
  state_t st;
  state_t st_next;
  res_t   res_calc;
  logic   adv;

  // Result register free or draining this cycle
  assign adv       = !res_valid || !res_stall;
  assign cmd_stall = in_valid && !adv;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!cmd_stall) begin
      in_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!cmd_stall && cmd_valid) begin
      in_word <= cmd_word;
    end
  end

  i2cm_step u_step (
    .st      (st),
    .item    (in_word),
    .st_next (st_next),
    .res     (res_calc)
  );

  // Engine state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid         <= 1'b0;
      st.active_command <= OP_TICK;
      st.step_count     <= 5'd0;
      st.shift_reg      <= 8'd0;
      st.scl_reg        <= 1'b1;
      st.sda_reg        <= 1'b1;
      st.ack_reg        <= 1'b0;
      st.rx_hold        <= 8'd0;
    end else if (in_valid && adv) begin
      res_valid <= 1'b1;
      st        <= st_next;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && adv) begin
      res_word <= res_calc;
    end
  end

endmodule

FILE: src/i2cm_checker.sv
module i2cm_checker (
  input logic           clk,
  input logic           rst,
  input logic           cmd_valid,
  input logic           cmd_stall,
  input i2cm_pkg::cmd_t cmd_word,
  input logic           res_valid,
  input logic           res_stall,
  input i2cm_pkg::res_t res_word
);
  import i2cm_pkg::*;

  // A stalled result word holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res_word))
    else $error("result word changed while stalled");

  // A finished command leaves the engine idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_word.done_res |-> !res_word.busy_res)
    else $error("done with busy still set");

  // Rejection only happens while busy, and never on a finishing tick
  a_rej_busy: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_word.rejected |-> res_word.busy_res && !res_word.done_res)
    else $error("rejected while idle or with done");

  // No result word right after reset
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");

endmodule

bind i2c_master_bit_engine i2cm_checker u_i2cm_checker (.*);
